>>> sv/cpfa_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// cpfa_pkg: shared types and constants of the page frame allocator
// Frame table size, reserved frames, derived widths, the controller state
// type and the command and status groups between controller and datapath.
// ----------------------------------------------------------------------------
package cpfa_pkg;

   // table geometry
   localparam int NUM_FRAMES      = 4096;
   localparam int RESERVED_FRAMES = 1139;

   // fixed field widths
   localparam int COUNT_W = 13;
   localparam int PAGE_W  = 12;

   // frame index width, and a working width that holds NUM_FRAMES itself
   // as well as any request count or page number
   localparam int FRAME_W = (NUM_FRAMES > 1) ? $clog2(NUM_FRAMES) : 1;
   localparam int IDX_W   = FRAME_W + 1;
   localparam int WIDE_W  = (IDX_W > COUNT_W) ? IDX_W : COUNT_W;

   // request action codes
   localparam logic ACT_ALLOC = 1'b0;
   localparam logic ACT_FREE  = 1'b1;

   // response status codes
   localparam logic STAT_OK   = 1'b0;
   localparam logic STAT_FAIL = 1'b1;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_SCAN,
      ST_WRITE,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic accept;      // latch request, arm scan or free
      logic scan_en;     // advance the first-fit scan
      logic mark_start;  // load the found run for marking
      logic write_en;    // write one mark of the current run
      logic fail;        // record a refused request
      logic clear_en;    // write one mark of the reset pattern
      logic rsp_load;    // move the result into the response register
   } cmd_type;

   typedef struct packed {
      logic is_free;     // incoming request frees frames
      logic req_bad;     // incoming allocate count is zero or too large
      logic hit;         // scan found a long enough run this cycle
      logic scan_end;    // scan checked the last frame
      logic write_done;  // run write has no frame left
      logic clear_done;  // reset pattern writes the last frame
      logic rsp_busy;    // response register still holds a transaction
   } stat_type;

endpackage
`default_nettype wire

>>> sv/cpfa_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// cpfa_ctrl: allocator controller
// Sequences the clearing pass, the first-fit scan, the run writes and the
// handoff of each result to the response register.
// ----------------------------------------------------------------------------
module cpfa_ctrl (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   output logic                    req_ready,
   input  wire cpfa_pkg::stat_type stat,
   output cpfa_pkg::cmd_type       cmd
);
   import cpfa_pkg::*;

   state_type state_ff;
   state_type state_in;

   // hold state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   // decide next state and commands
   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      case (state_ff)
         ST_CLEAR: begin
            cmd.clear_en = 1'b1;
            if (stat.clear_done) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.accept = 1'b1;
               if (stat.is_free) begin
                  state_in = ST_WRITE;
               end else if (stat.req_bad) begin
                  cmd.fail = 1'b1;
                  state_in = ST_DONE;
               end else begin
                  state_in = ST_SCAN;
               end
            end
         end
         ST_SCAN: begin
            cmd.scan_en = 1'b1;
            if (stat.hit) begin
               cmd.mark_start = 1'b1;
               state_in       = ST_WRITE;
            end else if (stat.scan_end) begin
               cmd.fail = 1'b1;
               state_in = ST_DONE;
            end
         end
         ST_WRITE: begin
            cmd.write_en = 1'b1;
            if (stat.write_done) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (!stat.rsp_busy) begin
               cmd.rsp_load = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule
`default_nettype wire

>>> sv/cpfa_datapath.sv
`default_nettype none
// ----------------------------------------------------------------------------
// cpfa_datapath: allocator datapath
// Frame mark memory, scan pointer and run tracking, run write pointer,
// result registers and the response output register.
// ----------------------------------------------------------------------------
module cpfa_datapath (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           req_action,
   input  wire logic [cpfa_pkg::COUNT_W-1:0]   req_page_count,
   input  wire logic [cpfa_pkg::PAGE_W-1:0]    req_page_number,
   output logic                                rsp_valid,
   input  wire logic                           rsp_ready,
   output logic                                rsp_status,
   output logic [cpfa_pkg::PAGE_W-1:0]         rsp_first_page,
   input  wire cpfa_pkg::cmd_type              cmd,
   output cpfa_pkg::stat_type                  stat
);
   import cpfa_pkg::*;

   localparam logic [WIDE_W-1:0] NUM_W  = WIDE_W'(NUM_FRAMES);
   localparam logic [WIDE_W-1:0] LAST_W = WIDE_W'(NUM_FRAMES - 1);
   localparam logic [WIDE_W-1:0] ONE_W  = WIDE_W'(1);

   // frame mark memory, one bit per frame
   logic mem [NUM_FRAMES];
   logic rdata_ff;

   logic [WIDE_W-1:0] count_ff,    count_in;
   logic [WIDE_W-1:0] scan_idx_ff, scan_idx_in;
   logic [WIDE_W-1:0] chk_idx_ff;
   logic              chk_vld_ff,  chk_vld_in;
   logic [WIDE_W-1:0] run_ff,      run_in;
   logic [WIDE_W-1:0] start_ff,    start_in;
   logic [WIDE_W-1:0] wr_idx_ff,   wr_idx_in;
   logic [WIDE_W-1:0] left_ff,     left_in;
   logic              wr_val_ff,   wr_val_in;
   logic              res_err_ff,  res_err_in;
   logic [PAGE_W-1:0] res_page_ff, res_page_in;
   logic              rsp_vld_ff,  rsp_vld_in;
   logic              rsp_stat_ff;
   logic [PAGE_W-1:0] rsp_page_ff;

   logic [WIDE_W-1:0] req_cnt_w;
   logic [WIDE_W-1:0] run_inc;
   logic [WIDE_W-1:0] run_first;
   logic              chk_free;
   logic              scan_more;
   logic              wr_done;
   logic              mem_we;
   logic              mem_wd;

   assign req_cnt_w = WIDE_W'(req_page_count);
   assign run_inc   = run_ff + ONE_W;
   assign chk_free  = chk_vld_ff && !rdata_ff;
   assign run_first = (run_ff == '0) ? chk_idx_ff : start_ff;
   assign scan_more = (scan_idx_ff < NUM_W);
   assign wr_done   = (left_ff == '0) || (wr_idx_ff >= NUM_W);

   // report status to the controller
   always_comb begin
      stat            = '0;
      stat.is_free    = (req_action == ACT_FREE);
      stat.req_bad    = (req_cnt_w == '0) || (req_cnt_w > NUM_W);
      stat.hit        = chk_free && (run_inc == count_ff);
      stat.scan_end   = chk_vld_ff && (chk_idx_ff == LAST_W);
      stat.write_done = wr_done;
      stat.clear_done = (wr_idx_ff == LAST_W);
      stat.rsp_busy   = rsp_vld_ff && !rsp_ready;
   end

   // drive memory writes for clearing and run writes
   always_comb begin
      mem_we = 1'b0;
      mem_wd = wr_val_ff;
      if (cmd.clear_en) begin
         mem_we = 1'b1;
         mem_wd = (32'(wr_idx_ff) < RESERVED_FRAMES);
      end else if (cmd.write_en && !wr_done) begin
         mem_we = 1'b1;
      end
   end

   // next values of the scan, run and result registers
   always_comb begin
      count_in    = count_ff;
      scan_idx_in = scan_idx_ff;
      chk_vld_in  = 1'b0;
      run_in      = run_ff;
      start_in    = start_ff;
      wr_idx_in   = wr_idx_ff;
      left_in     = left_ff;
      wr_val_in   = wr_val_ff;
      res_err_in  = res_err_ff;
      res_page_in = res_page_ff;

      // latch a new transaction
      if (cmd.accept) begin
         count_in    = req_cnt_w;
         scan_idx_in = '0;
         run_in      = '0;
         start_in    = '0;
         wr_idx_in   = WIDE_W'(req_page_number);
         left_in     = req_cnt_w;
         wr_val_in   = 1'b0;
         res_err_in  = STAT_OK;
         res_page_in = '0;
      end

      // advance the scan and track the current free run
      if (cmd.scan_en) begin
         if (scan_more) begin
            scan_idx_in = scan_idx_ff + ONE_W;
            chk_vld_in  = 1'b1;
         end
         if (chk_free) begin
            run_in   = run_inc;
            start_in = run_first;
         end else if (chk_vld_ff) begin
            run_in = '0;
         end
      end

      // load the found run for marking
      if (cmd.mark_start) begin
         wr_idx_in   = run_first;
         left_in     = count_ff;
         wr_val_in   = 1'b1;
         res_page_in = run_first[PAGE_W-1:0];
      end

      // step the write pointer
      if (cmd.clear_en) begin
         wr_idx_in = wr_idx_ff + ONE_W;
      end else if (cmd.write_en && !wr_done) begin
         wr_idx_in = wr_idx_ff + ONE_W;
         left_in   = left_ff - ONE_W;
      end

      if (cmd.fail) begin
         res_err_in  = STAT_FAIL;
         res_page_in = '0;
      end
   end

   // drop the response once taken, load a new one
   always_comb begin
      rsp_vld_in = rsp_vld_ff;
      if (rsp_vld_ff && rsp_ready) begin
         rsp_vld_in = 1'b0;
      end
      if (cmd.rsp_load) begin
         rsp_vld_in = 1'b1;
      end
   end

   // memory write and registered read
   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[wr_idx_ff[FRAME_W-1:0]] <= mem_wd;
      end
   end

   always_ff @(posedge clock) begin
      rdata_ff <= mem[scan_idx_ff[FRAME_W-1:0]];
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         chk_vld_ff <= 1'b0;
         wr_idx_ff  <= '0;
         rsp_vld_ff <= 1'b0;
      end else begin
         chk_vld_ff <= chk_vld_in;
         wr_idx_ff  <= wr_idx_in;
         rsp_vld_ff <= rsp_vld_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      count_ff    <= count_in;
      scan_idx_ff <= scan_idx_in;
      chk_idx_ff  <= scan_idx_ff;
      run_ff      <= run_in;
      start_ff    <= start_in;
      left_ff     <= left_in;
      wr_val_ff   <= wr_val_in;
      res_err_ff  <= res_err_in;
      res_page_ff <= res_page_in;
      if (cmd.rsp_load) begin
         rsp_stat_ff <= res_err_ff;
         rsp_page_ff <= res_page_ff;
      end
   end

   assign rsp_valid      = rsp_vld_ff;
   assign rsp_status     = rsp_stat_ff;
   assign rsp_first_page = rsp_page_ff;

endmodule
`default_nettype wire

>>> sv/contiguous_page_frame_allocator_unit.sv
`default_nettype none
// ----------------------------------------------------------------------------
// contiguous_page_frame_allocator_unit: first-fit page frame allocator
// Keeps one used/free mark per frame; allocates and frees contiguous runs.
// ----------------------------------------------------------------------------
// After reset the block runs a clearing pass that marks the lowest
// RESERVED_FRAMES frames used and the rest free; req_ready stays low until
// it ends. The marks live in a one-bit memory with one read and one write
// port, and that sets the timing. An allocate runs through acceptance, an
// upward scan from frame 0 (one frame per cycle), the marking of the run
// and the handoff of the result. A free marks its frames free one after
// another, stopping at the end of the table, then hands off. A zero or
// oversized allocate count is refused without a scan. The handoff waits while
// the response register still holds an untaken transaction. The block takes
// one transaction at a time; a finished result waits in the response register
// while the next transaction is accepted. Status 1 means no room, a zero
// count or an oversized count.
// ----------------------------------------------------------------------------
module contiguous_page_frame_allocator_unit (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         req_valid,
   output logic                              req_ready,
   input  wire logic                         req_action,
   input  wire logic [cpfa_pkg::COUNT_W-1:0] req_page_count,
   input  wire logic [cpfa_pkg::PAGE_W-1:0]  req_page_number,
   output logic                              rsp_valid,
   input  wire logic                         rsp_ready,
   output logic                              rsp_status,
   output logic [cpfa_pkg::PAGE_W-1:0]       rsp_first_page
);
   import cpfa_pkg::*;

   cmd_type  cmd;
   stat_type stat;

   // sequence the work
   cpfa_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   // hold marks, scan and answer
   cpfa_datapath u_datapath (
      .clock           (clock),
      .reset           (reset),
      .req_action      (req_action),
      .req_page_count  (req_page_count),
      .req_page_number (req_page_number),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_status      (rsp_status),
      .rsp_first_page  (rsp_first_page),
      .cmd             (cmd),
      .stat            (stat)
   );

endmodule
`default_nettype wire

>>> verif/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top: testbench of the first-fit contiguous page frame allocator
// Drives allocate and free requests through the valid/ready request channel,
// keeps its own copy of the frame map to predict every response, and checks
// each response transaction field by field in arrival order. A directed table
// covers count extremes, refusals and frees past the table; random traffic
// follows, with random idling on both channels and one long response stall.
// ----------------------------------------------------------------------------
module tb_top;
   import cpfa_pkg::*;

   localparam int CYCLE_LIMIT  = 6_000_000;
   localparam int DRAIN_CYCLES = 200;
   localparam int RANDOM_REQS  = 120;
   localparam int HOLD_AT      = 50;     // response index that starts the long stall
   localparam int HOLD_CYCLES  = 12000;

   typedef struct packed {
      logic               action;
      logic [COUNT_W-1:0] page_count;
      logic [PAGE_W-1:0]  page_number;
      logic               fixed;         // expected response typed in below
      logic               status;
      logic [PAGE_W-1:0]  first_page;
   } frame_req_row_type;

   typedef struct packed {
      logic              status;
      logic [PAGE_W-1:0] first_page;
   } frame_rsp_type;

   logic               clock;
   logic               reset;
   logic               req_valid;
   logic               req_ready;
   logic               req_action;
   logic [COUNT_W-1:0] req_page_count;
   logic [PAGE_W-1:0]  req_page_number;
   logic               rsp_valid;
   logic               rsp_ready;
   logic               rsp_status;
   logic [PAGE_W-1:0]  rsp_first_page;

   // shadow of the block's used/free marks
   bit                frame_map [NUM_FRAMES];
   // runs handed out and not yet returned, for well-formed frees
   int                held_run_base [$];
   int                held_run_len  [$];
   frame_rsp_type     expected_rsp_q [$];
   frame_req_row_type directed_reqs  [$];

   int mismatch_count = 0;
   int cycle_count    = 0;
   int offered_count  = 0;
   int rsp_seen       = 0;
   int alloc_placed   = 0;
   int alloc_refused  = 0;
   int free_count     = 0;

   contiguous_page_frame_allocator_unit u_top (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_action      (req_action),
      .req_page_count  (req_page_count),
      .req_page_number (req_page_number),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_status      (rsp_status),
      .rsp_first_page  (rsp_first_page)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // bound the run
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d responses pending",
                  cycle_count, expected_rsp_q.size());
         $display("status: fail");
         $finish;
      end
   end

   task automatic report_mismatch(input string msg);
      mismatch_count++;
      $display("[%0d] mismatch: %0s", cycle_count, msg);
   endtask

   // idle pattern: every third block of 20 transactions runs back to back
   function automatic int pick_idle(input int idx);
      if ((idx / 20) % 3 == 0)
         return 0;
      return $urandom_range(0, 18);
   endfunction

   // first-fit allocate or free on the shadow map; returns the response
   function automatic void apply_frame_request(input logic act,
                                               input logic [COUNT_W-1:0] cnt,
                                               input logic [PAGE_W-1:0] pg,
                                               output logic st,
                                               output logic [PAGE_W-1:0] fp);
      int  run_len;
      int  run_base;
      int  f;
      bit  found;
      st = STAT_FAIL;
      fp = '0;
      if (act == ACT_ALLOC) begin
         run_len  = 0;
         run_base = 0;
         found    = 1'b0;
         if (cnt != 0 && cnt <= NUM_FRAMES) begin
            for (f = 0; f < NUM_FRAMES && !found; f++) begin
               if (!frame_map[f]) begin
                  if (run_len == 0)
                     run_base = f;
                  run_len++;
                  if (run_len == cnt)
                     found = 1'b1;
               end else begin
                  run_len = 0;
               end
            end
         end
         if (found) begin
            for (f = run_base; f < run_base + cnt; f++)
               frame_map[f] = 1'b1;
            held_run_base.push_back(run_base);
            held_run_len.push_back(cnt);
            st = STAT_OK;
            fp = PAGE_W'(run_base);
            alloc_placed++;
         end else begin
            alloc_refused++;
         end
      end else begin
         // frames past the table are dropped
         for (f = pg; f < pg + cnt; f++)
            if (f < NUM_FRAMES)
               frame_map[f] = 1'b0;
         st = STAT_OK;
         free_count++;
      end
   endfunction

   task automatic add_row(input logic act, input int cnt, input int pg,
                          input logic fixed, input logic st, input int fp);
      frame_req_row_type row;
      row.action      = act;
      row.page_count  = COUNT_W'(cnt);
      row.page_number = PAGE_W'(pg);
      row.fixed       = fixed;
      row.status      = st;
      row.first_page  = PAGE_W'(fp);
      directed_reqs.push_back(row);
   endtask

   // offer one request transaction, hold it until accepted, then predict
   task automatic offer_request(input frame_req_row_type row);
      int         gap;
      logic       p_status;
      logic [PAGE_W-1:0] p_first;
      frame_rsp_type exp_rsp;
      gap = pick_idle(offered_count);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid       <= 1'b1;
      req_action      <= row.action;
      req_page_count  <= row.page_count;
      req_page_number <= row.page_number;
      @(negedge clock);
      while (req_ready !== 1'b1) begin
         @(posedge clock);
         @(negedge clock);
      end
      @(posedge clock);
      offered_count++;
      apply_frame_request(row.action, row.page_count, row.page_number, p_status, p_first);
      if (row.fixed) begin
         exp_rsp.status     = row.status;
         exp_rsp.first_page = row.first_page;
      end else begin
         exp_rsp.status     = p_status;
         exp_rsp.first_page = p_first;
      end
      expected_rsp_q.push_back(exp_rsp);
   endtask

   // response side: random stalls, one long hold, in-order checking
   initial begin : rsp_side
      int                gap;
      logic              got_status;
      logic [PAGE_W-1:0] got_first;
      frame_rsp_type     exp_rsp;
      rsp_ready <= 1'b0;
      @(posedge clock);
      while (reset !== 1'b0) @(posedge clock);
      forever begin
         if (rsp_seen == HOLD_AT)
            gap = HOLD_CYCLES;
         else
            gap = pick_idle(rsp_seen);
         if (gap > 0) begin
            rsp_ready <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         @(negedge clock);
         while (rsp_valid !== 1'b1) begin
            @(posedge clock);
            @(negedge clock);
         end
         got_status = rsp_status;
         got_first  = rsp_first_page;
         @(posedge clock);
         rsp_seen++;
         if (expected_rsp_q.size() == 0) begin
            report_mismatch($sformatf("response %0d arrived with none expected", rsp_seen));
         end else begin
            exp_rsp = expected_rsp_q.pop_front();
            if (got_status !== exp_rsp.status)
               report_mismatch($sformatf("response %0d status %b, expected %b",
                                         rsp_seen, got_status, exp_rsp.status));
            if (got_first !== exp_rsp.first_page)
               report_mismatch($sformatf("response %0d first_page %0d, expected %0d",
                                         rsp_seen, got_first, exp_rsp.first_page));
         end
      end
   end

   initial begin : req_side
      int                i;
      int                r;
      int                k;
      int                cnt;
      frame_req_row_type row;
      reset           <= 1'b1;
      req_valid       <= 1'b0;
      req_action      <= ACT_ALLOC;
      req_page_count  <= '0;
      req_page_number <= '0;
      for (i = 0; i < NUM_FRAMES; i++)
         frame_map[i] = (i < RESERVED_FRAMES);

      // directed table: count extremes, refusals, frees past and across the table
      add_row(ACT_ALLOC, 0, 4095, 1'b1, STAT_FAIL, 0);             // zero count
      add_row(ACT_ALLOC, 8191, 0, 1'b1, STAT_FAIL, 0);             // all count bits set
      add_row(ACT_ALLOC, NUM_FRAMES + 1, 0, 1'b1, STAT_FAIL, 0);   // longer than table
      add_row(ACT_ALLOC, NUM_FRAMES, 0, 1'b1, STAT_FAIL, 0);       // reserved frames in the way
      add_row(ACT_ALLOC, 1, 0, 1'b1, STAT_OK, RESERVED_FRAMES);    // first free frame
      add_row(ACT_ALLOC, 16, 0, 1'b0, STAT_OK, 0);
      add_row(ACT_FREE, 1, RESERVED_FRAMES, 1'b1, STAT_OK, 0);
      add_row(ACT_ALLOC, 1, 0, 1'b0, STAT_OK, 0);                  // reuse the hole
      add_row(ACT_ALLOC, NUM_FRAMES - RESERVED_FRAMES - 17, 0, 1'b0, STAT_OK, 0);
      add_row(ACT_ALLOC, 1, 0, 1'b0, STAT_OK, 0);                  // table full
      add_row(ACT_FREE, 0, 0, 1'b1, STAT_OK, 0);                   // zero-count free
      add_row(ACT_FREE, 8191, 4095, 1'b1, STAT_OK, 0);             // reaches past table
      add_row(ACT_ALLOC, 1, 0, 1'b0, STAT_OK, 0);
      add_row(ACT_FREE, NUM_FRAMES, 0, 1'b1, STAT_OK, 0);          // clears reserved too
      add_row(ACT_FREE, 8, 100, 1'b1, STAT_OK, 0);                 // already free
      add_row(ACT_ALLOC, NUM_FRAMES, 0, 1'b1, STAT_OK, 0);         // whole table
      add_row(ACT_ALLOC, 1, 0, 1'b0, STAT_OK, 0);
      add_row(ACT_FREE, NUM_FRAMES / 2, NUM_FRAMES / 2, 1'b1, STAT_OK, 0);
      add_row(ACT_ALLOC, NUM_FRAMES / 2 + 1, 0, 1'b0, STAT_OK, 0);
      add_row(ACT_ALLOC, NUM_FRAMES / 2, 0, 1'b0, STAT_OK, 0);
      add_row(ACT_FREE, NUM_FRAMES, 0, 1'b1, STAT_OK, 0);
      add_row(ACT_ALLOC, RESERVED_FRAMES, 0, 1'b0, STAT_OK, 0);    // restore low block

      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // walk the directed table
      foreach (directed_reqs[i])
         offer_request(directed_reqs[i]);

      // random traffic: mostly allocate/free pairs, some refusals and stray frees
      for (i = 0; i < RANDOM_REQS; i++) begin
         r = $urandom_range(0, 99);
         row.fixed       = 1'b0;
         row.status      = STAT_OK;
         row.first_page  = '0;
         row.page_number = PAGE_W'($urandom_range(0, NUM_FRAMES - 1));
         if (r < 45 || (r < 80 && held_run_base.size() == 0)) begin
            cnt = ($urandom_range(0, 9) == 0) ? $urandom_range(25, 600)
                                              : $urandom_range(1, 24);
            row.action     = ACT_ALLOC;
            row.page_count = COUNT_W'(cnt);
         end else if (r < 80) begin
            // return a run that was handed out
            k = $urandom_range(0, held_run_base.size() - 1);
            row.action      = ACT_FREE;
            row.page_number = PAGE_W'(held_run_base[k]);
            row.page_count  = COUNT_W'(held_run_len[k]);
            held_run_base.delete(k);
            held_run_len.delete(k);
         end else if (r < 86) begin
            row.action     = ACT_ALLOC;
            row.page_count = ($urandom_range(0, 2) == 0) ? '0
                             : COUNT_W'($urandom_range(NUM_FRAMES + 1, 8191));
         end else if (r < 92) begin
            row.action     = ACT_FREE;
            row.page_count = COUNT_W'($urandom_range(0, 64));
         end else begin
            row.action     = ACT_ALLOC;
            row.page_count = COUNT_W'($urandom_range(600, NUM_FRAMES));
         end
         offer_request(row);
      end
      req_valid <= 1'b0;

      // drain outstanding responses
      while (expected_rsp_q.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (expected_rsp_q.size() != 0)
         report_mismatch($sformatf("%0d responses never arrived", expected_rsp_q.size()));

      $display("covered %0d requests: %0d allocations placed, %0d refused, %0d frees",
               offered_count, alloc_placed, alloc_refused, free_count);
      $display("checked %0d responses with one %0d-cycle response stall, %0d mismatches",
               rsp_seen, HOLD_CYCLES, mismatch_count);
      if (mismatch_count == 0)
         $display("status: pass");
      else
         $display("status: fail");
      $finish;
   end

endmodule

>>> filelist.f
sv/cpfa_pkg.sv
sv/cpfa_ctrl.sv
sv/cpfa_datapath.sv
sv/contiguous_page_frame_allocator_unit.sv
verif/tb_top.sv
